[sv/iodcs_pkg.sv]
package iodcs_pkg;

  localparam int IODCS_DEVICES     = 16;
  localparam int IODCS_MAX_RETRIES = 5;

  localparam logic [15:0] FRAME_ID_BASE    = 16'h8000;
  localparam logic [15:0] WATCHDOG_DEFAULT = 16'd100;

  typedef enum logic [2:0] {
    ST_OFFLINE    = 3'd0,
    ST_IDENTIFY   = 3'd1,
    ST_CONNECT    = 3'd2,
    ST_PRM_END    = 3'd3,
    ST_WAIT_READY = 3'd4,
    ST_EXCHANGE   = 3'd5,
    ST_FAULT      = 3'd6
  } conn_state_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_DEVICES  = 2'd0,
    CFG_STRICT_MASK     = 2'd1,
    CFG_MAC_KNOWN_MASK  = 2'd2,
    CFG_WATCHDOG_FACTOR = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_STEP      = 1'b0,
    OP_CYCLE_END = 1'b1
  } opcode_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EXEC = 1'b1
  } seq_state_e;

  typedef struct packed {
    conn_state_e conn_state;
    logic [2:0]  retry_count;
    logic [15:0] missed_count;
    logic [15:0] cycle_seq;
    logic [31:0] error_tally;
    logic [31:0] reconnect_tally;
    logic [31:0] good_tally;
  } dev_entry_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] device_index;
    logic       step_ok;
    logic       frame_received;
  } req_t;

  typedef struct packed {
    logic [2:0]  device_state;
    logic [15:0] frame_counter;
    logic        release_request;
    logic        clear_buffers;
    logic [31:0] error_total;
    logic [31:0] reconnect_total;
    logic [31:0] good_cycle_total;
    logic [15:0] in_frame_id;
    logic [15:0] out_frame_id;
    logic        ignored;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_stat_t;

endpackage

[sv/iodcs_if.sv]
interface iodcs_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] device_index;
  logic       step_ok;
  logic       frame_received;

  modport source (output valid, output opcode, output device_index, output step_ok,
                  output frame_received, input ready);
  modport sink (input valid, input opcode, input device_index, input step_ok,
                input frame_received, output ready);
endinterface

interface iodcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  device_state;
  logic [15:0] frame_counter;
  logic        release_request;
  logic        clear_buffers;
  logic [31:0] error_total;
  logic [31:0] reconnect_total;
  logic [31:0] good_cycle_total;
  logic [15:0] in_frame_id;
  logic [15:0] out_frame_id;
  logic        ignored;

  modport source (output valid, output device_state, output frame_counter,
                  output release_request, output clear_buffers, output error_total,
                  output reconnect_total, output good_cycle_total, output in_frame_id,
                  output out_frame_id, output ignored, input ready);
  modport sink (input valid, input device_state, input frame_counter,
                input release_request, input clear_buffers, input error_total,
                input reconnect_total, input good_cycle_total, input in_frame_id,
                input out_frame_id, input ignored, output ready);
endinterface

interface iodcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/iodcs_ctrl.sv]
module iodcs_ctrl import iodcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (req_valid_i) state_d = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        if (stat_i.out_free) state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      SEQ_EXEC: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

[sv/iodcs_dp.sv]
module iodcs_dp import iodcs_pkg::*; #(
  parameter int DEVICES     = IODCS_DEVICES,
  parameter int MAX_RETRIES = IODCS_MAX_RETRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output ctrl_stat_t  stat_o,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  cfg_reg_e    cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        rsp_ready_i,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o
);

  localparam int AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  // configuration registers
  logic [4:0]  active_q;
  logic [15:0] strict_q, mac_q, wdog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      strict_q <= '0;
      mac_q    <= '0;
      wdog_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_DEVICES:  active_q <= cfg_data_i[4:0];
        CFG_STRICT_MASK:     strict_q <= cfg_data_i;
        CFG_MAC_KNOWN_MASK:  mac_q    <= cfg_data_i;
        CFG_WATCHDOG_FACTOR: wdog_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // device table, valid bit per entry stands in for the cleared contents
  dev_entry_t   mem_q [DEVICES];
  logic [DEVICES-1:0] vld_q;

  req_t        item_q;
  logic [AW-1:0] addr_q;
  dev_entry_t  rd_q;
  logic        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q   <= req_i;
      addr_q   <= AW'(req_i.device_index);
      rd_q     <= mem_q[AW'(req_i.device_index)];
      rd_vld_q <= vld_q[AW'(req_i.device_index)];
    end
  end

  // entry update
  dev_entry_t  cur, nxt;
  logic        ign, release_req, clear_buf;
  logic        strict_bit, mac_bit;
  logic [2:0]  retry_inc;
  logic [15:0] missed_inc, wd_limit;

  always_comb begin
    cur         = rd_vld_q ? rd_q : '0;
    nxt         = cur;
    release_req = 1'b0;
    clear_buf   = 1'b0;
    strict_bit  = strict_q[item_q.device_index];
    mac_bit     = mac_q[item_q.device_index];
    ign         = !(({1'b0, item_q.device_index} < active_q) &&
                    ({28'd0, item_q.device_index} < 32'(DEVICES)));
    retry_inc   = (cur.retry_count == 3'd7) ? 3'd7 : cur.retry_count + 3'd1;
    missed_inc  = cur.missed_count + 16'd1;
    wd_limit    = (wdog_q == '0) ? WATCHDOG_DEFAULT : wdog_q;

    if (item_q.opcode == OP_STEP) begin
      if (cur.conn_state == ST_OFFLINE) begin
        nxt.conn_state = ST_IDENTIFY;
      end else if ((cur.conn_state == ST_IDENTIFY) && (mac_bit || item_q.step_ok)) begin
        nxt.conn_state = ST_CONNECT;
      end else if ((cur.conn_state == ST_CONNECT) && item_q.step_ok) begin
        nxt.conn_state = ST_PRM_END;
      end else if ((cur.conn_state == ST_PRM_END) && item_q.step_ok) begin
        nxt.conn_state = ST_WAIT_READY;
      end else if ((cur.conn_state == ST_WAIT_READY) && item_q.step_ok) begin
        nxt.retry_count  = '0;
        nxt.missed_count = '0;
        nxt.cycle_seq    = '0;
        nxt.conn_state   = ST_EXCHANGE;
        clear_buf        = 1'b1;
      end else if ((cur.conn_state == ST_IDENTIFY) || (cur.conn_state == ST_CONNECT) ||
                   (cur.conn_state == ST_PRM_END) || (cur.conn_state == ST_WAIT_READY)) begin
        // failed step
        nxt.error_tally = cur.error_tally + 32'd1;
        if (strict_bit && (retry_inc >= 3'(MAX_RETRIES))) begin
          nxt.conn_state  = ST_FAULT;
          nxt.retry_count = '0;
        end else begin
          nxt.conn_state  = ST_OFFLINE;
          nxt.retry_count = retry_inc;
        end
      end
    end else if (cur.conn_state == ST_EXCHANGE) begin
      nxt.cycle_seq = cur.cycle_seq + 16'd1;
      if (item_q.frame_received) begin
        nxt.missed_count = '0;
        nxt.good_tally   = cur.good_tally + 32'd1;
      end else begin
        nxt.error_tally  = cur.error_tally + 32'd1;
        nxt.missed_count = missed_inc;
        if (missed_inc >= wd_limit) begin
          release_req         = 1'b1;
          nxt.reconnect_tally = cur.reconnect_tally + 32'd1;
          nxt.retry_count     = '0;
          nxt.missed_count    = '0;
          nxt.conn_state      = ST_OFFLINE;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !ign) begin
      mem_q[addr_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.commit && !ign) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // result register
  rsp_t rsp_d, rsp_q;
  logic out_vld_q, out_vld_d;

  always_comb begin
    rsp_d                  = '0;
    rsp_d.in_frame_id      = FRAME_ID_BASE | {11'd0, item_q.device_index, 1'b1};
    rsp_d.out_frame_id     = FRAME_ID_BASE | {11'd0, item_q.device_index, 1'b0};
    rsp_d.ignored          = ign;
    if (!ign) begin
      rsp_d.device_state     = nxt.conn_state;
      rsp_d.frame_counter    = nxt.cycle_seq;
      rsp_d.release_request  = release_req;
      rsp_d.clear_buffers    = clear_buf;
      rsp_d.error_total      = nxt.error_tally;
      rsp_d.reconnect_total  = nxt.reconnect_tally;
      rsp_d.good_cycle_total = nxt.good_tally;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.commit) begin
      out_vld_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  assign stat_o.out_free = !out_vld_q || rsp_ready_i;
  assign rsp_valid_o     = out_vld_q;
  assign rsp_o           = rsp_q;

endmodule

[sv/io_device_connection_sequencer.sv]
// a request and its table entry are captured into registers; no new request is taken until
// the updated entry and the result are written, once the output register is free
// a pending result sits in an output register, the next item is taken meanwhile
// reset: asynchronous, active low; clears config registers, control and the table valid bits
// configuration port is always ready
module io_device_connection_sequencer import iodcs_pkg::*; #(
  parameter int DEVICES     = IODCS_DEVICES,
  parameter int MAX_RETRIES = IODCS_MAX_RETRIES
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  iodcs_req_if.sink   req_i,
  iodcs_rsp_if.source rsp_o,
  iodcs_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  req_t       req;
  rsp_t       rsp;
  logic       rsp_valid;

  // pack the incoming transaction
  assign req.opcode         = req_i.opcode;
  assign req.device_index   = req_i.device_index;
  assign req.step_ok        = req_i.step_ok;
  assign req.frame_received = req_i.frame_received;

  // register writes are always accepted, no back pressure
  assign cfg_i.ready = 1'b1;

  // sequencing of capture and commit
  iodcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // device table, per-device state update and result register
  iodcs_dp #(
    .DEVICES     (DEVICES),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_reg_e'(cfg_i.index)),
    .cfg_data_i  (cfg_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  // unpack the result transaction
  assign rsp_o.valid            = rsp_valid;
  assign rsp_o.device_state     = rsp.device_state;
  assign rsp_o.frame_counter    = rsp.frame_counter;
  assign rsp_o.release_request  = rsp.release_request;
  assign rsp_o.clear_buffers    = rsp.clear_buffers;
  assign rsp_o.error_total      = rsp.error_total;
  assign rsp_o.reconnect_total  = rsp.reconnect_total;
  assign rsp_o.good_cycle_total = rsp.good_cycle_total;
  assign rsp_o.in_frame_id      = rsp.in_frame_id;
  assign rsp_o.out_frame_id     = rsp.out_frame_id;
  assign rsp_o.ignored          = rsp.ignored;

endmodule

[tb/io_device_connection_sequencer_tb.sv]
`timescale 1ns / 1ps

module io_device_connection_sequencer_tb;
  import iodcs_pkg::*;

  // longest legal stretch without any transaction is the long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 250;
  localparam int unsigned DIRECTED_ROWS = 25;
  // rows before this one run with the reset configuration (no active devices)
  localparam int unsigned FIRST_ACTIVE_ROW = 2;

  // one row of the directed table; pinned rows carry an expectation typed in by hand
  typedef struct packed {
    opcode_e     op;
    logic [3:0]  idx;
    logic        ok;
    logic        rx;
    logic        pinned;
    conn_state_e st;
    logic [31:0] errs;
    logic [15:0] in_id;
    logic [15:0] out_id;
    logic        ign;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset configuration: everything is ignored, only frame ids come back
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b1, ST_OFFLINE,  32'd0, 16'h8001, 16'h8000, 1'b1},
    '{OP_CYCLE_END, 4'd15, 1'b1, 1'b1, 1'b1, ST_OFFLINE,  32'd0, 16'h801F, 16'h801E, 1'b1},
    // device 0 is strict: five failed attempts end in fault
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b1, ST_IDENTIFY, 32'd0, 16'h8001, 16'h8000, 1'b0},
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b1, ST_OFFLINE,  32'd1, 16'h8001, 16'h8000, 1'b0},
    '{OP_STEP,      4'd0,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b0, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b1, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd0,  1'b0, 1'b0, 1'b1, ST_FAULT,    32'd5, 16'h8001, 16'h8000, 1'b0},
    // fault is sticky for steps and cycle ends
    '{OP_STEP,      4'd0,  1'b1, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_CYCLE_END, 4'd0,  1'b1, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    // device 1 has a known address: failed identify still connects
    '{OP_STEP,      4'd1,  1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd1,  1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd1,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd1,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd1,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    // good cycle, then a miss trips the watchdog of one cycle
    '{OP_CYCLE_END, 4'd1,  1'b0, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_CYCLE_END, 4'd1,  1'b1, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_CYCLE_END, 4'd1,  1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    // device 15, not strict: a failed connect just drops back to offline
    '{OP_STEP,      4'd15, 1'b0, 1'b0, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd15, 1'b1, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0},
    '{OP_STEP,      4'd15, 1'b0, 1'b1, 1'b0, ST_OFFLINE,  32'd0, 16'h0,    16'h0,    1'b0}
  };

  logic clk_i;
  logic rst_ni;

  iodcs_req_if req_if ();
  iodcs_rsp_if rsp_if ();
  iodcs_cfg_if cfg_if ();

  io_device_connection_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // hand-typed expectation travels alongside the request it belongs to
  logic pinned_vld;
  rsp_t pinned_rsp;

  // idling controls shared between the stimulus and the receiver
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_req;

  int unsigned fail_count;
  int unsigned quiet_cycles;

  // shadow of the configuration registers
  logic [4:0]  active_q;
  logic [15:0] strict_q;
  logic [15:0] mac_q;
  logic [15:0] wd_q;

  // shadow of the per-device connection table
  conn_state_e dev_state  [IODCS_DEVICES];
  logic [2:0]  dev_retry  [IODCS_DEVICES];
  logic [15:0] dev_missed [IODCS_DEVICES];
  logic [15:0] dev_seq    [IODCS_DEVICES];
  logic [31:0] dev_err    [IODCS_DEVICES];
  logic [31:0] dev_reconn [IODCS_DEVICES];
  logic [31:0] dev_good   [IODCS_DEVICES];

  // device status reports still owed by the block, oldest first
  rsp_t awaited_status_q [$];

  initial begin
    clk_i = 1'b0;
  end
  always #4 clk_i = ~clk_i;

  // failed step: count it, bump retries, strict devices give up after the limit
  function automatic void note_failed_step(input logic [3:0] d);
    dev_err[d] = dev_err[d] + 32'd1;
    if (dev_retry[d] != 3'd7) dev_retry[d] = dev_retry[d] + 3'd1;
    if (strict_q[d] && dev_retry[d] >= IODCS_MAX_RETRIES) begin
      dev_state[d] = ST_FAULT;
      dev_retry[d] = '0;
    end else begin
      dev_state[d] = ST_OFFLINE;
    end
  endfunction

  // applies one request to the shadow table and returns the status report it causes
  function automatic rsp_t predict_device_status(input logic op, input logic [3:0] d,
                                                 input logic ok, input logic rx);
    rsp_t        r;
    logic [4:0]  limit;
    logic [15:0] wd;
    r = '0;
    r.in_frame_id  = FRAME_ID_BASE + {11'd0, d, 1'b1};
    r.out_frame_id = FRAME_ID_BASE + {11'd0, d, 1'b0};
    limit = (active_q < IODCS_DEVICES) ? active_q : 5'(IODCS_DEVICES);
    if ({1'b0, d} >= limit) begin
      r.ignored = 1'b1;
      return r;
    end
    if (op == OP_STEP) begin
      case (dev_state[d])
        ST_OFFLINE: dev_state[d] = ST_IDENTIFY;
        ST_IDENTIFY: begin
          if (mac_q[d] || ok) dev_state[d] = ST_CONNECT;
          else note_failed_step(d);
        end
        ST_CONNECT: begin
          if (ok) dev_state[d] = ST_PRM_END;
          else note_failed_step(d);
        end
        ST_PRM_END: begin
          if (ok) dev_state[d] = ST_WAIT_READY;
          else note_failed_step(d);
        end
        ST_WAIT_READY: begin
          if (ok) begin
            dev_retry[d]    = '0;
            dev_missed[d]   = '0;
            dev_seq[d]      = '0;
            r.clear_buffers = 1'b1;
            dev_state[d]    = ST_EXCHANGE;
          end else begin
            note_failed_step(d);
          end
        end
        default: ;
      endcase
    end else if (dev_state[d] == ST_EXCHANGE) begin
      dev_seq[d] = dev_seq[d] + 16'd1;
      if (rx) begin
        dev_missed[d] = '0;
        dev_good[d]   = dev_good[d] + 32'd1;
      end else begin
        wd = (wd_q != '0) ? wd_q : WATCHDOG_DEFAULT;
        dev_missed[d] = dev_missed[d] + 16'd1;
        dev_err[d]    = dev_err[d] + 32'd1;
        // watchdog expired: release the association and start over
        if (dev_missed[d] >= wd) begin
          r.release_request = 1'b1;
          dev_reconn[d] = dev_reconn[d] + 32'd1;
          dev_retry[d]  = '0;
          dev_missed[d] = '0;
          dev_state[d]  = ST_OFFLINE;
        end
      end
    end
    r.device_state     = dev_state[d];
    r.frame_counter    = dev_seq[d];
    r.error_total      = dev_err[d];
    r.reconnect_total  = dev_reconn[d];
    r.good_cycle_total = dev_good[d];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // monitor: shadows config writes, predicts on accepted requests,
  // checks every accepted status report, and watches for a hang
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      active_q = '0;
      strict_q = '0;
      mac_q    = '0;
      wd_q     = '0;
      for (int i = 0; i < IODCS_DEVICES; i++) begin
        dev_state[i]  = ST_OFFLINE;
        dev_retry[i]  = '0;
        dev_missed[i] = '0;
        dev_seq[i]    = '0;
        dev_err[i]    = '0;
        dev_reconn[i] = '0;
        dev_good[i]   = '0;
      end
      quiet_cycles = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_ACTIVE_DEVICES:  active_q = cfg_if.data[4:0];
          CFG_STRICT_MASK:     strict_q = cfg_if.data;
          CFG_MAC_KNOWN_MASK:  mac_q    = cfg_if.data;
          CFG_WATCHDOG_FACTOR: wd_q     = cfg_if.data;
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        // predictor always runs so the shadow table stays in step
        exp_rsp = predict_device_status(req_if.opcode, req_if.device_index,
                                        req_if.step_ok, req_if.frame_received);
        awaited_status_q.push_back(pinned_vld ? pinned_rsp : exp_rsp);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_status_q.size() == 0) begin
          $error("status report with no request outstanding");
          fail_count++;
        end else begin
          exp_rsp = awaited_status_q.pop_front();
          check_field("device_state", 32'(exp_rsp.device_state), 32'(rsp_if.device_state));
          check_field("frame_counter", 32'(exp_rsp.frame_counter),
                      32'(rsp_if.frame_counter));
          check_field("release_request", 32'(exp_rsp.release_request),
                      32'(rsp_if.release_request));
          check_field("clear_buffers", 32'(exp_rsp.clear_buffers),
                      32'(rsp_if.clear_buffers));
          check_field("error_total", exp_rsp.error_total, rsp_if.error_total);
          check_field("reconnect_total", exp_rsp.reconnect_total, rsp_if.reconnect_total);
          check_field("good_cycle_total", exp_rsp.good_cycle_total,
                      rsp_if.good_cycle_total);
          check_field("in_frame_id", 32'(exp_rsp.in_frame_id), 32'(rsp_if.in_frame_id));
          check_field("out_frame_id", 32'(exp_rsp.out_frame_id), 32'(rsp_if.out_frame_id));
          check_field("ignored", 32'(exp_rsp.ignored), 32'(rsp_if.ignored));
        end
      end
      // hang detection: any transaction on any channel counts as progress
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stall per report, plus one long hold-off on request
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // offers one request, after a random gap if sender idling is on, and returns at the edge it is taken
  task automatic send_request(input opcode_e op, input logic [3:0] idx, input logic ok,
                              input logic rx, input logic pinned, input rsp_t pin_rsp);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.opcode         <= op;
    req_if.device_index   <= idx;
    req_if.step_ok        <= ok;
    req_if.frame_received <= rx;
    pinned_vld            <= pinned;
    pinned_rsp            <= pin_rsp;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop offering and wait until every owed report has been taken
  task automatic drain_reports();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_status_q.size() != 0);
  endtask

  task automatic put_register(input cfg_reg_e idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // all four registers back to back, valid held high across them
  task automatic program_registers(input logic [4:0] n_dev, input logic [15:0] strict,
                                   input logic [15:0] mac, input logic [15:0] wd);
    put_register(CFG_ACTIVE_DEVICES, {11'd0, n_dev});
    put_register(CFG_STRICT_MASK, strict);
    put_register(CFG_MAC_KNOWN_MASK, mac);
    put_register(CFG_WATCHDOG_FACTOR, wd);
    cfg_if.valid <= 1'b0;
  endtask

  // random traffic over a device range; ok and rx biases steer how far devices get
  task automatic exercise_devices(input int unsigned count, input int unsigned idx_lo,
                                  input int unsigned idx_hi, input int unsigned cycle_pct,
                                  input int unsigned ok_pct, input int unsigned rx_pct,
                                  input bit vary_idle);
    opcode_e op;
    for (int unsigned i = 0; i < count; i++) begin
      // change idling now and then so some stretches run back to back
      if (vary_idle && (i % 40) == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      op = ($urandom_range(0, 99) < cycle_pct) ? OP_CYCLE_END : OP_STEP;
      send_request(op, 4'($urandom_range(idx_lo, idx_hi)),
                   $urandom_range(0, 99) < ok_pct, $urandom_range(0, 99) < rx_pct,
                   1'b0, '0);
    end
  endtask

  initial begin
    rsp_t pin;
    rst_ni        <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= OP_STEP;
    req_if.device_index   <= '0;
    req_if.step_ok        <= 1'b0;
    req_if.frame_received <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_ACTIVE_DEVICES;
    cfg_if.data  <= '0;
    pinned_vld   <= 1'b0;
    pinned_rsp   <= '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    long_hold_req = 1'b0;
    fail_count    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: first rows with reset config, then a fixed setup
    for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == FIRST_ACTIVE_ROW) begin
        drain_reports();
        // strict device 0, known address on device 1, watchdog of one cycle
        program_registers(5'd16, 16'h0001, 16'h0002, 16'd1);
      end
      pin = '0;
      pin.device_state = DIRECTED[i].st;
      pin.error_total  = DIRECTED[i].errs;
      pin.in_frame_id  = DIRECTED[i].in_id;
      pin.out_frame_id = DIRECTED[i].out_id;
      pin.ignored      = DIRECTED[i].ign;
      send_request(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].ok, DIRECTED[i].rx,
                   DIRECTED[i].pinned, pin);
    end
    drain_reports();

    // all devices, random masks, short watchdog; sender pauses midway for a full drain
    program_registers(5'd16, 16'($urandom), 16'($urandom), 16'd3);
    exercise_devices(150, 0, 15, 40, 85, 70, 1'b1);
    drain_reports();
    exercise_devices(150, 0, 15, 40, 85, 70, 1'b1);
    drain_reports();

    // no active devices: everything is ignored
    program_registers(5'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
    exercise_devices(30, 0, 15, 50, 50, 50, 1'b1);
    drain_reports();

    // two devices on the default watchdog, mostly missed frames
    program_registers(5'd2, 16'h0000, 16'hFFFF, 16'd0);
    exercise_devices(450, 0, 3, 70, 90, 10, 1'b1);
    drain_reports();

    // active count above the table size, all strict, long watchdog, frequent failures
    program_registers(5'd31, 16'hFFFF, 16'h0000, 16'hFFFF);
    exercise_devices(300, 8, 15, 30, 60, 50, 1'b1);
    drain_reports();

    // receiver holds off while the sender keeps pushing, so the block backs up
    program_registers(5'd8, 16'h0000, 16'($urandom), 16'($urandom_range(1, 8)));
    tx_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    exercise_devices(60, 0, 9, 40, 75, 60, 1'b0);
    exercise_devices(400, 0, 9, 40, 75, 60, 1'b1);
    drain_reports();

    // let any stray report surface before the verdict
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
